// ----- rtl/core/spi_master_shifter_core_defines.svh -----
// Assertion helpers for the core RTL, used by spi_msc_engine.
`ifndef SPI_MASTER_SHIFTER_CORE_DEFINES_SVH
`define SPI_MASTER_SHIFTER_CORE_DEFINES_SVH

// Checked only outside reset.
`define SMC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define SMC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/spi_msc_pkg.sv -----
`timescale 1ns / 1ps

package spi_msc_pkg;

   localparam int BYTE_BITS_DEFAULT = 8;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_POLARITY     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_PHASE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LSB_FIRST          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SELECT_ACTIVE_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD        = 3'd4;

   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_DATA_W-1:0] HALF_PERIOD_RESET = 16'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] tx_byte;
      logic       end_frame;
      logic       miso;
   } req_type;

   typedef struct packed {
      logic       sck;
      logic       mosi;
      logic       select_line;
      logic       busy_res;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       cmd_rejected;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       end_frame;
      logic       miso;
   } item_type;

   typedef struct packed {
      logic                  en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } cfg_wr_type;

endpackage

// ----- rtl/core/spi_master_shifter_core.sv -----
`timescale 1ns / 1ps

// SPI master, modes 0 to 3, advanced by one tick request per clock cycle. Each
// request yields exactly one response with the SCK, MOSI and select levels after
// that tick, plus busy, finished read byte and reject flags. Requests are taken
// at one per cycle sustained while the response queue is not full; a response
// becomes available once its request has passed the request queue and then the
// sequencer update into the response queue. Both queues hold two entries. CSR
// writes are registered and must be issued only while no request is in flight.
module spi_master_shifter_core import spi_msc_pkg::*; #(
   parameter int BYTE_BITS = BYTE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   input  logic                  valid,
   output logic                  ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   item_type   item;
   logic       item_valid;
   logic       item_take;
   cfg_wr_type cfg_wr;

   assign ready        = 1'b1;
   assign cfg_wr.en    = valid;
   assign cfg_wr.index = csr_index;
   assign cfg_wr.data  = csr_data;

   spi_msc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take)
   );

   spi_msc_engine #(
      .BYTE_BITS (BYTE_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .cfg_wr     (cfg_wr),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/core/spi_msc_front.sv -----
`timescale 1ns / 1ps

module spi_msc_front import spi_msc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   output item_type item,
   output logic     item_valid,
   input  logic     item_take
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       take;
   item_type   classified;

   always_comb begin
      classified.tx_byte   = req_data.tx_byte;
      classified.end_frame = req_data.end_frame;
      classified.miso      = req_data.miso;
      unique case (req_data.cmd)
         CMD_WRITE: classified.op = OP_WRITE;
         CMD_READ:  classified.op = OP_READ;
         default:   classified.op = OP_TICK;
      endcase
   end

   assign full       = (count_ff == 2'd2);
   assign accept     = push && !full;
   assign item_valid = (count_ff != 2'd0);
   assign take       = item_take && item_valid;
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(accept) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ----- rtl/core/spi_msc_engine.sv -----
`timescale 1ns / 1ps
`include "spi_master_shifter_core_defines.svh"

module spi_msc_engine import spi_msc_pkg::*; #(
   parameter int BYTE_BITS = BYTE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       item_valid,
   output logic       item_take,
   input  cfg_wr_type cfg_wr,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data
);

   localparam int BI_W = (BYTE_BITS > 1) ? $clog2(BYTE_BITS) : 1;
   localparam logic [BI_W-1:0] LAST_BIT = BI_W'(BYTE_BITS - 1);

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_LEAD    = 5'b00010,
      PH_FIRST   = 5'b00100,
      PH_SECOND  = 5'b01000,
      PH_RELEASE = 5'b10000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [15:0]           tick_ff, tick_in;
   logic [BI_W-1:0]       bit_ff, bit_in;
   logic [BYTE_BITS-1:0]  shift_ff, shift_in;
   logic                  sck_ff, sck_in;
   logic                  mosi_ff, mosi_in;
   logic                  sel_ff, sel_in;
   logic                  endp_ff, endp_in;
   logic                  rd_ff, rd_in;

   logic                  pol_ff, pol_in;
   logic                  cpha_ff, cpha_in;
   logic                  lsb_ff, lsb_in;
   logic                  sah_ff, sah_in;
   logic [15:0]           half_ff, half_in;

   logic                  fire;
   logic [15:0]           hp;
   logic [15:0]           tick_inc;
   logic [BYTE_BITS:0]    act;
   logic                  rx_valid;
   logic [BYTE_BITS-1:0]  rx_word;
   logic                  rej;
   logic [BYTE_BITS+7:0]  tx_wide;
   logic [BYTE_BITS+7:0]  rx_wide;
   rsp_type               rsp_new;

   rsp_type               out_ff [2];
   logic                  out_wr_ff, out_wr_in;
   logic                  out_rd_ff, out_rd_in;
   logic [1:0]            out_count_ff, out_count_in;
   logic                  out_take;

   // Returns {shift, mosi} after one bit slot: sample for a read, drive for a write.
   function automatic logic [BYTE_BITS:0] bit_act(
      input logic                 is_rd,
      input logic                 lsb,
      input logic [BI_W-1:0]      idx,
      input logic [BYTE_BITS-1:0] shreg,
      input logic                 mosi_cur,
      input logic                 miso
   );
      logic [BI_W-1:0]      pos;
      logic [BYTE_BITS-1:0] sh;
      logic                 mo;
      pos = lsb ? idx : (LAST_BIT - idx);
      sh  = shreg;
      mo  = mosi_cur;
      if (is_rd) begin
         sh = shreg | (BYTE_BITS'(miso) << pos);
      end else begin
         mo = lsb ? shreg[0] : shreg[BYTE_BITS-1];
      end
      return {sh, mo};
   endfunction

   assign fire      = item_valid && (out_count_ff != 2'd2);
   assign item_take = fire;
   assign hp        = (half_ff == 16'd0) ? 16'd1 : half_ff;
   assign tick_inc  = tick_ff + 16'd1;
   assign tx_wide   = {{BYTE_BITS{1'b0}}, item.tx_byte};

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      sck_in   = sck_ff;
      mosi_in  = mosi_ff;
      sel_in   = sel_ff;
      endp_in  = endp_ff;
      rd_in    = rd_ff;
      pol_in   = pol_ff;
      cpha_in  = cpha_ff;
      lsb_in   = lsb_ff;
      sah_in   = sah_ff;
      half_in  = half_ff;
      rx_valid = 1'b0;
      rx_word  = '0;
      rej      = 1'b0;
      act      = '0;

      if (cfg_wr.en) begin
         unique case (cfg_wr.index)
            CSR_CLOCK_POLARITY: begin
               pol_in = cfg_wr.data[0];
               if (phase_ff == PH_IDLE) begin
                  sck_in = cfg_wr.data[0];
               end
            end
            CSR_CLOCK_PHASE:        cpha_in = cfg_wr.data[0];
            CSR_LSB_FIRST:          lsb_in  = cfg_wr.data[0];
            CSR_SELECT_ACTIVE_HIGH: sah_in  = cfg_wr.data[0];
            CSR_HALF_PERIOD:        half_in = cfg_wr.data;
            default: ;
         endcase
      end

      if (fire) begin
         if (phase_ff == PH_IDLE) begin
            if (item.op == OP_WRITE || item.op == OP_READ) begin
               rd_in    = (item.op == OP_READ);
               shift_in = rd_in ? '0 : tx_wide[BYTE_BITS-1:0];
               endp_in  = item.end_frame;
               bit_in   = '0;
               tick_in  = 16'd0;
               sel_in   = 1'b1;
               phase_in = PH_LEAD;
            end
         end else begin
            rej     = (item.op == OP_WRITE || item.op == OP_READ);
            tick_in = tick_inc;
            if (tick_inc >= hp || tick_inc == 16'd0) begin
               tick_in = 16'd0;
               unique case (phase_ff)
                  PH_LEAD: begin
                     phase_in = PH_FIRST;
                     bit_in   = '0;
                     if (!cpha_ff) begin
                        act      = bit_act(rd_ff, lsb_ff, '0, shift_ff, mosi_ff, item.miso);
                        shift_in = act[BYTE_BITS:1];
                        mosi_in  = act[0];
                     end
                  end
                  PH_FIRST: begin
                     sck_in = ~sck_ff;
                     if (cpha_ff) begin
                        act      = bit_act(rd_ff, lsb_ff, bit_ff, shift_ff, mosi_ff, item.miso);
                        shift_in = act[BYTE_BITS:1];
                        mosi_in  = act[0];
                     end
                     phase_in = PH_SECOND;
                  end
                  PH_SECOND: begin
                     sck_in = ~sck_ff;
                     if (!rd_ff) begin
                        shift_in = lsb_ff ? (shift_ff >> 1) : (shift_ff << 1);
                     end
                     if (bit_ff == LAST_BIT) begin
                        sck_in = pol_ff;
                        if (rd_ff) begin
                           rx_valid = 1'b1;
                           rx_word  = shift_in;
                        end
                        if (endp_ff) begin
                           if (!rd_ff) begin
                              mosi_in = 1'b0;
                           end
                           phase_in = PH_RELEASE;
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end else begin
                        bit_in   = bit_ff + 1'b1;
                        phase_in = PH_FIRST;
                        if (!cpha_ff) begin
                           act      = bit_act(rd_ff, lsb_ff, bit_in, shift_in, mosi_ff,
                                              item.miso);
                           shift_in = act[BYTE_BITS:1];
                           mosi_in  = act[0];
                        end
                     end
                  end
                  PH_RELEASE: begin
                     sel_in   = 1'b0;
                     endp_in  = 1'b0;
                     phase_in = PH_IDLE;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end
   end

   assign rx_wide = {8'd0, rx_word};

   always_comb begin
      rsp_new.sck          = sck_in;
      rsp_new.mosi         = mosi_in;
      rsp_new.select_line  = sah_in ? sel_in : ~sel_in;
      rsp_new.busy_res     = (phase_in != PH_IDLE);
      rsp_new.rx_byte      = rx_wide[7:0];
      rsp_new.rx_valid     = rx_valid;
      rsp_new.cmd_rejected = rej;
   end

   assign empty    = (out_count_ff == 2'd0);
   assign out_take = pop && !empty;
   assign rsp_data = out_ff[out_rd_ff];

   always_comb begin
      out_wr_in    = fire ? ~out_wr_ff : out_wr_ff;
      out_rd_in    = out_take ? ~out_rd_ff : out_rd_ff;
      out_count_in = out_count_ff + 2'(fire) - 2'(out_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= 16'd0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         sck_ff       <= 1'b0;
         mosi_ff      <= 1'b0;
         sel_ff       <= 1'b0;
         endp_ff      <= 1'b0;
         rd_ff        <= 1'b0;
         pol_ff       <= 1'b0;
         cpha_ff      <= 1'b0;
         lsb_ff       <= 1'b0;
         sah_ff       <= 1'b0;
         half_ff      <= HALF_PERIOD_RESET;
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         sck_ff       <= sck_in;
         mosi_ff      <= mosi_in;
         sel_ff       <= sel_in;
         endp_ff      <= endp_in;
         rd_ff        <= rd_in;
         pol_ff       <= pol_in;
         cpha_ff      <= cpha_in;
         lsb_ff       <= lsb_in;
         sah_ff       <= sah_in;
         half_ff      <= half_in;
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff[out_wr_ff] <= rsp_new;
      end
   end

   `SMC_ASSERT(a_rej_only_busy, clock, reset, rej |-> (phase_ff != PH_IDLE), "reject while idle")
   `SMC_ASSERT(a_out_bound, clock, reset, out_count_ff != 2'd3, "result queue overflow")
   `SMC_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (phase_ff == PH_IDLE && !sel_ff), "not idle after reset")

endmodule
